>>> rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bilinear resize sampler
// field widths, op and register codes, and the control bundle of the blend
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // item field widths
  localparam int PIX_W   = 16;
  localparam int IDX_W   = 7;
  localparam int PLANE_W = 2;
  localparam int SIZE_W  = 8;
  localparam int SCALE_W = 23;
  localparam int FRAC_W  = 16;

  // scale * index, integer part and the widened size compare
  localparam int POS_W   = SCALE_W + IDX_W;
  localparam int IP_W    = POS_W - FRAC_W;
  localparam int SZX_W   = 13;

  // op codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COLS = 2'd3;

  typedef logic signed [PIX_W-1:0] pixel_t;
  typedef logic [FRAC_W-1:0]       frac_t;

  typedef struct packed {
    logic query;     // a query item sits in this stage
    logic plane_ok;  // its plane exists
  } blend_ctl_t;

endpackage

`default_nettype wire

>>> rtl/brs_bank.sv
// ----------------------------------------------------------------------------
// brs_bank: one parity bank of the pixel store
// single shared address port for write and read, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module brs_bank #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       addr,
  input  wire brs_pkg::pixel_t     wdata,
  output brs_pkg::pixel_t          rdata
);

  brs_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/brs_blend.sv
// ----------------------------------------------------------------------------
// brs_blend: weighted blend of four neighbors
// column lerp, row lerp, round to nearest; three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module brs_blend (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brs_pkg::blend_ctl_t ctl,
  input  wire brs_pkg::pixel_t     p00,
  input  wire brs_pkg::pixel_t     p01,
  input  wire brs_pkg::pixel_t     p10,
  input  wire brs_pkg::pixel_t     p11,
  input  wire brs_pkg::frac_t      fx,
  input  wire brs_pkg::frac_t      fy,
  output logic                     done,
  output brs_pkg::pixel_t          pixel_out
);

  localparam int ROW_W = 34;
  localparam int SUM_W = 52;

  // stage d: horizontal blend, p0 * 2^16 + (p1 - p0) * fx
  logic signed [16:0]      dtop;
  logic signed [16:0]      dbot;
  logic signed [16:0]      fx_s;
  logic signed [ROW_W-1:0] top_next;
  logic signed [ROW_W-1:0] bot_next;

  brs_pkg::blend_ctl_t     ctl4;
  logic signed [ROW_W-1:0] top4;
  logic signed [ROW_W-1:0] bot4;
  brs_pkg::frac_t          fy4;

  always_comb begin
    dtop     = {p01[15], p01} - {p00[15], p00};
    dbot     = {p11[15], p11} - {p10[15], p10};
    fx_s     = {1'b0, fx};
    top_next = $signed({{2{p00[15]}}, p00, 16'h0000}) + dtop * fx_s;
    bot_next = $signed({{2{p10[15]}}, p10, 16'h0000}) + dbot * fx_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else begin
      ctl4 <= ctl;
    end
    top4 <= top_next;
    bot4 <= bot_next;
    fy4  <= fy;
  end

  // stage e: vertical blend, exact q.32 sum
  logic signed [ROW_W:0]   dtb;
  logic signed [16:0]      fy_s;
  logic signed [SUM_W-1:0] sum_next;

  brs_pkg::blend_ctl_t     ctl5;
  logic signed [SUM_W-1:0] sum5;

  always_comb begin
    dtb      = {bot4[ROW_W-1], bot4} - {top4[ROW_W-1], top4};
    fy_s     = {1'b0, fy4};
    sum_next = $signed({{2{top4[ROW_W-1]}}, top4, 16'h0000}) + dtb * fy_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else begin
      ctl5 <= ctl4;
    end
    sum5 <= sum_next;
  end

  // stage f: round half up, saturate
  logic signed [SUM_W-1:0] biased;
  logic signed [19:0]      res;
  brs_pkg::pixel_t         sat;

  always_comb begin
    biased = sum5 + SUM_W'(64'sd2147483648);
    res    = biased[SUM_W-1:32];
    if (res > 20'sd32767) begin
      sat = 16'sh7fff;
    end else if (res < -20'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl5.query;
    end
    pixel_out <= ctl5.plane_ok ? sat : '0;
  end

endmodule

`default_nettype wire

>>> rtl/bilinear_resize_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_resize_sampler_top: corner-aligned bilinear resize sampler
// loads fill a pixel store split into four row/column parity banks; queries
// map an output pixel onto the source grid and blend four neighbors
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------------
//   item in   op, plane, row, col, pixel_in           start high, busy low
//   result    pixel_out                               done high for one cycle
//   config    cfg_we, cfg_index, cfg_data             cfg_we high, no wait
//
// one item accepted per cycle; busy never rises since nothing in the pipe waits
// a query's result passes the input register, locate, bank read, column blend,
// row blend and round stages; loads give no result
// the four parity banks each take one access per cycle, so all four neighbors
// come out of one read; rst is synchronous and clears valid bits and config
// the store keeps its contents and needs no clearing pass; no receiver stall
//
`default_nettype none

module bilinear_resize_sampler_top #(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_PLANES = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // item in
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 op,
  input  wire logic [brs_pkg::PLANE_W-1:0]          plane,
  input  wire logic [brs_pkg::IDX_W-1:0]            row,
  input  wire logic [brs_pkg::IDX_W-1:0]            col,
  input  wire brs_pkg::pixel_t                      pixel_in,
  // result
  output logic                                      done,
  output brs_pkg::pixel_t                           pixel_out,
  // config
  input  wire logic                                 cfg_we,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [brs_pkg::SCALE_W-1:0]          cfg_data
);

  // index widths and bank geometry
  localparam int RI_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CI_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HALF_H      = (MAX_HEIGHT + 1) / 2;
  localparam int HALF_W      = (MAX_WIDTH + 1) / 2;
  localparam int PLANE_WORDS = HALF_H * HALF_W;
  localparam int BANK_DEPTH  = MAX_PLANES * PLANE_WORDS;
  localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [brs_pkg::SZX_W-1:0] MAXH = brs_pkg::SZX_W'(MAX_HEIGHT);
  localparam logic [brs_pkg::SZX_W-1:0] MAXW = brs_pkg::SZX_W'(MAX_WIDTH);

  // nothing in the pipe ever holds an item back
  assign busy = 1'b0;

  // ---------------------------------------------------------------- config
  logic [brs_pkg::SIZE_W-1:0]  in_height;
  logic [brs_pkg::SIZE_W-1:0]  in_width;
  logic [brs_pkg::SCALE_W-1:0] scale_rows;
  logic [brs_pkg::SCALE_W-1:0] scale_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height  <= brs_pkg::SIZE_W'(1);
      in_width   <= brs_pkg::SIZE_W'(1);
      scale_rows <= '0;
      scale_cols <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brs_pkg::REG_IN_HEIGHT:  in_height  <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::REG_IN_WIDTH:   in_width   <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::REG_SCALE_ROWS: scale_rows <= cfg_data;
        brs_pkg::REG_SCALE_COLS: scale_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // last source row and column: zero size acts as one, oversize saturates
  logic [brs_pkg::SZX_W-1:0] h_ext;
  logic [brs_pkg::SZX_W-1:0] w_ext;
  logic [brs_pkg::SZX_W-1:0] last_row;
  logic [brs_pkg::SZX_W-1:0] last_col;

  always_comb begin
    h_ext = brs_pkg::SZX_W'(in_height);
    w_ext = brs_pkg::SZX_W'(in_width);
    if (h_ext == '0) begin
      last_row = '0;
    end else if (h_ext > MAXH) begin
      last_row = MAXH - brs_pkg::SZX_W'(1);
    end else begin
      last_row = h_ext - brs_pkg::SZX_W'(1);
    end
    if (w_ext == '0) begin
      last_col = '0;
    end else if (w_ext > MAXW) begin
      last_col = MAXW - brs_pkg::SZX_W'(1);
    end else begin
      last_col = w_ext - brs_pkg::SZX_W'(1);
    end
  end

  // ------------------------------------------- stage 1: input register, scale
  logic                                accept;
  logic                                v1;
  logic                                op1;
  logic [brs_pkg::PLANE_W-1:0]         plane1;
  logic [brs_pkg::IDX_W-1:0]           row1;
  logic [brs_pkg::IDX_W-1:0]           col1;
  brs_pkg::pixel_t                     pix1;
  logic [brs_pkg::POS_W-1:0]           pos_r1;
  logic [brs_pkg::POS_W-1:0]           pos_c1;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    op1    <= op;
    plane1 <= plane;
    row1   <= row;
    col1   <= col;
    pix1   <= pixel_in;
    // source position in q.16: ratio times output index
    pos_r1 <= brs_pkg::POS_W'(scale_rows) * brs_pkg::POS_W'(row);
    pos_c1 <= brs_pkg::POS_W'(scale_cols) * brs_pkg::POS_W'(col);
  end

  // ------------------------------- stage 2: locate neighbors, bank addresses
  function automatic logic [AW-1:0] word_addr(input int pl, input int rh, input int ch);
    int a;
    a = pl * PLANE_WORDS + rh * HALF_W + ch;
    return AW'(a);
  endfunction

  logic [brs_pkg::IP_W-1:0]  ip_r;
  logic [brs_pkg::IP_W-1:0]  ip_c;
  logic                      clamp_r;
  logic                      clamp_c;
  logic [RI_W-1:0]           r0;
  logic [RI_W-1:0]           r1;
  logic [CI_W-1:0]           c0;
  logic [CI_W-1:0]           c1;
  brs_pkg::frac_t            fy_n;
  brs_pkg::frac_t            fx_n;
  logic                      plane_ok;
  logic                      load_ok;
  logic                      is_query;
  logic [3:0]                we_n;
  logic [AW-1:0]             addr_n [4];

  always_comb begin
    ip_r    = pos_r1[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
    ip_c    = pos_c1[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
    clamp_r = ip_r >= brs_pkg::IP_W'(last_row);
    clamp_c = ip_c >= brs_pkg::IP_W'(last_col);

    // at or past the last row or column both neighbors are the edge pixel
    r0   = clamp_r ? last_row[RI_W-1:0] : ip_r[RI_W-1:0];
    r1   = clamp_r ? r0 : r0 + RI_W'(1);
    c0   = clamp_c ? last_col[CI_W-1:0] : ip_c[CI_W-1:0];
    c1   = clamp_c ? c0 : c0 + CI_W'(1);
    fy_n = clamp_r ? '0 : pos_r1[brs_pkg::FRAC_W-1:0];
    fx_n = clamp_c ? '0 : pos_c1[brs_pkg::FRAC_W-1:0];

    plane_ok = int'(plane1) < MAX_PLANES;
    load_ok  = plane_ok && (int'(row1) < MAX_HEIGHT) && (int'(col1) < MAX_WIDTH);
    is_query = (op1 == brs_pkg::OP_QUERY);

    for (int b = 0; b < 4; b++) begin
      if (!is_query) begin
        addr_n[b] = word_addr(int'(plane1), int'(row1 >> 1), int'(col1 >> 1));
        we_n[b]   = v1 && load_ok && ({row1[0], col1[0]} == 2'(b));
      end else begin
        // bank (rp, cp) holds whichever neighbor row / column has that parity
        addr_n[b] = word_addr(plane_ok ? int'(plane1) : 0,
                              int'(((r0[0] == b[1]) ? r0 : r1) >> 1),
                              int'(((c0[0] == b[0]) ? c0 : c1) >> 1));
        we_n[b]   = 1'b0;
      end
    end
  end

  logic                q2;
  logic [3:0]          we2;
  logic [AW-1:0]       addr2 [4];
  brs_pkg::pixel_t     pix2;
  logic                r0p2;
  logic                c0p2;
  logic                req2;
  logic                ceq2;
  brs_pkg::frac_t      fy2;
  brs_pkg::frac_t      fx2;
  logic                pok2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2  <= 1'b0;
      we2 <= '0;
    end else begin
      q2  <= v1 && is_query;
      we2 <= we_n;
    end
    for (int b = 0; b < 4; b++) begin
      addr2[b] <= addr_n[b];
    end
    pix2 <= pix1;
    r0p2 <= r0[0];
    c0p2 <= c0[0];
    req2 <= clamp_r;
    ceq2 <= clamp_c;
    fy2  <= fy_n;
    fx2  <= fx_n;
    pok2 <= plane_ok;
  end

  // ------------------------------------------ stage 3: parity banks, one read
  brs_pkg::pixel_t rd3 [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    brs_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (we2[g]),
      .addr  (addr2[g]),
      .wdata (pix2),
      .rdata (rd3[g])
    );
  end

  logic            q3;
  logic            r0p3;
  logic            c0p3;
  logic            req3;
  logic            ceq3;
  brs_pkg::frac_t  fy3;
  brs_pkg::frac_t  fx3;
  logic            pok3;

  always_ff @(posedge clk) begin
    if (rst) begin
      q3 <= 1'b0;
    end else begin
      q3 <= q2;
    end
    r0p3 <= r0p2;
    c0p3 <= c0p2;
    req3 <= req2;
    ceq3 <= ceq2;
    fy3  <= fy2;
    fx3  <= fx2;
    pok3 <= pok2;
  end

  // --------------------------------- stages 4 to 6: route neighbors, blend
  logic                rb1;
  logic                cb1;
  brs_pkg::pixel_t     p00;
  brs_pkg::pixel_t     p01;
  brs_pkg::pixel_t     p10;
  brs_pkg::pixel_t     p11;
  brs_pkg::blend_ctl_t ctl3;

  always_comb begin
    // a clamped edge reuses the same bank for the far neighbor
    rb1  = req3 ? r0p3 : !r0p3;
    cb1  = ceq3 ? c0p3 : !c0p3;
    p00  = rd3[{r0p3, c0p3}];
    p01  = rd3[{r0p3, cb1}];
    p10  = rd3[{rb1, c0p3}];
    p11  = rd3[{rb1, cb1}];
    ctl3.query    = q3;
    ctl3.plane_ok = pok3;
  end

  brs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl3),
    .p00       (p00),
    .p01       (p01),
    .p10       (p10),
    .p11       (p11),
    .fx        (fx3),
    .fy        (fy3),
    .done      (done),
    .pixel_out (pixel_out)
  );

  // ------------------------------------------------------------- assertions
  // every result comes from an accepted query
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && op == brs_pkg::OP_QUERY, 6))
    else $error("result without a matching query");

  // a load writes at most one parity bank
  a_one_bank: assert property (@(posedge clk) disable iff (rst)
    $onehot0(we2))
    else $error("load writes more than one bank");

  // a clamped edge carries zero weight toward the far neighbor
  a_clamp_weight: assert property (@(posedge clk) disable iff (rst)
    q2 |-> ((!req2 || fy2 == '0) && (!ceq2 || fx2 == '0)))
    else $error("nonzero weight at a clamped edge");

  // reset flushes the pipe
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

`default_nettype wire
